>>> design/inorm_pkg.sv
// ----------------------------------------------------------------------------
// inorm_pkg
// Shared types and constants for the instance normalization block.
// ----------------------------------------------------------------------------
package inorm_pkg;

   localparam int SAMPLE_W   = 16;
   localparam int SUM_W      = 22;
   localparam int SQ_W       = 31;
   localparam int QSUM_W     = 37;
   localparam int IDX_W      = 6;
   localparam int ALU_W      = 64;
   localparam int STEP_W     = 7;
   localparam int ROOT_W     = 25;
   localparam int GAIN_W     = 37;
   localparam int DEV_W      = 24;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;

   localparam logic [CSR_IDX_W-1:0] CSR_AFFINE  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_EPSILON = 2'd1;

   localparam logic signed [SAMPLE_W-1:0] GAMMA_ONE = 16'sd4096;

   localparam logic [STEP_W-1:0] STEPS_NQ   = 7'd7;
   localparam logic [STEP_W-1:0] STEPS_SS   = 7'd22;
   localparam logic [STEP_W-1:0] STEPS_VAR  = 7'd44;
   localparam logic [STEP_W-1:0] STEPS_ROOT = 7'd24;
   localparam logic [STEP_W-1:0] STEPS_GAIN = 7'd37;
   localparam logic [STEP_W-1:0] STEPS_PROD = 7'd23;
   localparam logic [STEP_W-1:0] STEPS_QUOT = 7'd60;

   typedef enum logic [1:0] {
      ALU_MUL,
      ALU_DIV,
      ALU_SQRT
   } alu_op_type;

   typedef enum logic [3:0] {
      S_LOAD,
      S_SETTLE,
      S_NQ,
      S_SS,
      S_VAR,
      S_ROOT,
      S_GAIN,
      S_READ,
      S_FETCH,
      S_PROD,
      S_QUOT,
      S_EMIT
   } seq_state_type;

   typedef struct packed {
      logic                 start;
      alu_op_type           op;
      logic [STEP_W-1:0]    steps;
      logic [ALU_W-1:0]     opa;
      logic [ALU_W-1:0]     opb;
   } alu_cmd_type;

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] sample;
      logic signed [SAMPLE_W-1:0] scale_gamma;
      logic signed [SAMPLE_W-1:0] shift_beta;
      logic                       last_element;
   } req_item_type;

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] normalized;
      logic [IDX_W-1:0]           element_index;
      logic                       last_result;
   } rsp_item_type;

endpackage

>>> design/instance_normalization.sv
// ----------------------------------------------------------------------------
// instance_normalization
// Buffers one channel instance, derives mean, variance and gain on a shared
// iterative unit, then streams every stored element out normalized.
// ----------------------------------------------------------------------------
// loading: one item per cycle until the item marked last
// after the last item: statistics on the shared unit (multiply, divide and
// square root steps), then for each result one 23-step multiply and one
// 60-step divide; no items meanwhile
// reset is synchronous; registers return to affine on, epsilon 1
// ----------------------------------------------------------------------------
module instance_normalization #(
   parameter int MAX_ELEMS = 64
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  inorm_pkg::req_item_type                req_item,
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output inorm_pkg::rsp_item_type                rsp_item,
   input  logic                                   csr_wr_en,
   input  logic [inorm_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [inorm_pkg::CSR_DATA_W-1:0]       csr_wdata
);

   localparam int ADDR_W = (MAX_ELEMS > 1) ? $clog2(MAX_ELEMS) : 1;
   localparam int CNT_W  = $clog2(MAX_ELEMS + 1);
   localparam int W      = inorm_pkg::ALU_W;

   inorm_pkg::seq_state_type state_ff, state_in;

   logic                                affine_ff;
   logic [inorm_pkg::CSR_DATA_W-1:0]    eps_ff;
   logic [CNT_W-1:0]                    count_ff;
   logic signed [inorm_pkg::SUM_W-1:0]  sum_ff;
   logic [inorm_pkg::QSUM_W-1:0]        qsum_ff;
   logic [inorm_pkg::SQ_W-1:0]          sq_ff;
   logic                                sq_vld_ff;
   logic signed [inorm_pkg::SAMPLE_W-1:0] held_gamma_ff;
   logic signed [inorm_pkg::SAMPLE_W-1:0] held_beta_ff;
   logic                                issued_ff;
   logic [W-1:0]                        work_ff;
   logic [inorm_pkg::ROOT_W-1:0]        root_ff;
   logic [inorm_pkg::GAIN_W-1:0]        gain_mag_ff;
   logic                                gain_neg_ff;
   logic [inorm_pkg::DEV_W-2:0]         dev_mag_ff;
   logic                                dev_neg_ff;
   logic                                prod_neg_ff;
   logic [ADDR_W-1:0]                   idx_ff;
   logic                                rsp_valid_ff;
   inorm_pkg::rsp_item_type             rsp_item_ff;
   logic signed [inorm_pkg::SAMPLE_W-1:0] y_ff;

   inorm_pkg::alu_cmd_type              alu_cmd;
   logic                                alu_done;
   logic [W-1:0]                        alu_res;

   logic                                accept;
   logic                                store;
   logic [inorm_pkg::SAMPLE_W-1:0]      rd_data;
   logic                                out_free;
   logic                                last_idx;
   logic signed [inorm_pkg::SAMPLE_W-1:0] gamma_sel;
   logic signed [inorm_pkg::SAMPLE_W-1:0] beta_sel;
   logic [inorm_pkg::SAMPLE_W-1:0]      gamma_mag;
   logic [inorm_pkg::SUM_W-1:0]         sum_mag;
   logic signed [inorm_pkg::DEV_W-1:0]  dev;
   logic [W-1:0]                        num_diff;
   logic signed [W-1:0]                 quot_s;
   logic signed [W-1:0]                 y_wide;
   logic signed [inorm_pkg::SAMPLE_W-1:0] y_sat;

   assign accept    = req_valid && !req_stall;
   assign store     = accept && (count_ff < CNT_W'(MAX_ELEMS));
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign last_idx  = (CNT_W'(idx_ff) + CNT_W'(1)) == count_ff;
   assign gamma_sel = affine_ff ? held_gamma_ff : inorm_pkg::GAMMA_ONE;
   assign beta_sel  = affine_ff ? held_beta_ff : '0;
   assign gamma_mag = gamma_sel[inorm_pkg::SAMPLE_W-1] ? 16'(-gamma_sel) : 16'(gamma_sel);
   assign sum_mag   = sum_ff[inorm_pkg::SUM_W-1] ? 22'(-sum_ff) : 22'(sum_ff);
   assign dev       = $signed({1'b0, 7'(count_ff)}) * $signed(rd_data)
                      - inorm_pkg::DEV_W'(sum_ff);
   assign num_diff  = work_ff - alu_res;

   always_comb begin
      quot_s = prod_neg_ff ? -$signed(alu_res) : $signed(alu_res);
      y_wide = W'(beta_sel) + quot_s;
      if (y_wide > 64'sd32767) begin
         y_sat = 16'sh7fff;
      end else if (y_wide < -64'sd32768) begin
         y_sat = -16'sh8000;
      end else begin
         y_sat = y_wide[inorm_pkg::SAMPLE_W-1:0];
      end
   end

   inorm_ram #(
      .WIDTH (inorm_pkg::SAMPLE_W),
      .DEPTH (MAX_ELEMS)
   ) u_buf (
      .clock   (clock),
      .wr_en   (store),
      .wr_addr (count_ff[ADDR_W-1:0]),
      .wr_data (req_item.sample),
      .rd_addr (idx_ff),
      .rd_data (rd_data)
   );

   inorm_alu u_alu (
      .clock  (clock),
      .reset  (reset),
      .cmd    (alu_cmd),
      .done   (alu_done),
      .result (alu_res)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         inorm_pkg::S_LOAD:   if (accept && req_item.last_element) state_in = inorm_pkg::S_SETTLE;
         inorm_pkg::S_SETTLE: state_in = inorm_pkg::S_NQ;
         inorm_pkg::S_NQ:     if (alu_done) state_in = inorm_pkg::S_SS;
         inorm_pkg::S_SS:     if (alu_done) state_in = inorm_pkg::S_VAR;
         inorm_pkg::S_VAR:    if (alu_done) state_in = inorm_pkg::S_ROOT;
         inorm_pkg::S_ROOT:   if (alu_done) state_in = inorm_pkg::S_GAIN;
         inorm_pkg::S_GAIN:   if (root_ff == '0 || alu_done) state_in = inorm_pkg::S_READ;
         inorm_pkg::S_READ:   state_in = inorm_pkg::S_FETCH;
         inorm_pkg::S_FETCH:  state_in = inorm_pkg::S_PROD;
         inorm_pkg::S_PROD:   if (alu_done) state_in = inorm_pkg::S_QUOT;
         inorm_pkg::S_QUOT:   if (alu_done) state_in = inorm_pkg::S_EMIT;
         inorm_pkg::S_EMIT: begin
            if (out_free) begin
               state_in = last_idx ? inorm_pkg::S_LOAD : inorm_pkg::S_READ;
            end
         end
         default:             state_in = inorm_pkg::S_LOAD;
      endcase
   end

   // shared unit commands
   always_comb begin
      alu_cmd   = '0;
      req_stall = (state_ff != inorm_pkg::S_LOAD);
      unique case (state_ff)
         inorm_pkg::S_NQ: begin
            alu_cmd.start = !issued_ff;
            alu_cmd.op    = inorm_pkg::ALU_MUL;
            alu_cmd.steps = inorm_pkg::STEPS_NQ;
            alu_cmd.opa   = W'(qsum_ff);
            alu_cmd.opb   = W'(count_ff);
         end
         inorm_pkg::S_SS: begin
            alu_cmd.start = !issued_ff;
            alu_cmd.op    = inorm_pkg::ALU_MUL;
            alu_cmd.steps = inorm_pkg::STEPS_SS;
            alu_cmd.opa   = W'(sum_mag);
            alu_cmd.opb   = W'(sum_mag);
         end
         inorm_pkg::S_VAR: begin
            alu_cmd.start = !issued_ff;
            alu_cmd.op    = inorm_pkg::ALU_DIV;
            alu_cmd.steps = inorm_pkg::STEPS_VAR;
            alu_cmd.opa   = work_ff;
            alu_cmd.opb   = W'(count_ff * count_ff);
         end
         inorm_pkg::S_ROOT: begin
            alu_cmd.start = !issued_ff;
            alu_cmd.op    = inorm_pkg::ALU_SQRT;
            alu_cmd.steps = inorm_pkg::STEPS_ROOT;
            alu_cmd.opa   = work_ff;
            alu_cmd.opb   = '0;
         end
         inorm_pkg::S_GAIN: begin
            alu_cmd.start = !issued_ff && (root_ff != '0);
            alu_cmd.op    = inorm_pkg::ALU_DIV;
            alu_cmd.steps = inorm_pkg::STEPS_GAIN;
            alu_cmd.opa   = (W'(gamma_mag) << 20) + W'(root_ff >> 1);
            alu_cmd.opb   = W'(root_ff);
         end
         inorm_pkg::S_PROD: begin
            alu_cmd.start = !issued_ff;
            alu_cmd.op    = inorm_pkg::ALU_MUL;
            alu_cmd.steps = inorm_pkg::STEPS_PROD;
            alu_cmd.opa   = W'(gain_mag_ff);
            alu_cmd.opb   = W'(dev_mag_ff);
         end
         inorm_pkg::S_QUOT: begin
            alu_cmd.start = !issued_ff;
            alu_cmd.op    = inorm_pkg::ALU_DIV;
            alu_cmd.steps = inorm_pkg::STEPS_QUOT;
            alu_cmd.opa   = work_ff;
            alu_cmd.opb   = W'(count_ff) << 16;
         end
         default: begin
            alu_cmd = '0;
         end
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= inorm_pkg::S_LOAD;
         affine_ff     <= 1'b1;
         eps_ff        <= 16'd1;
         count_ff      <= '0;
         sum_ff        <= '0;
         qsum_ff       <= '0;
         sq_vld_ff     <= 1'b0;
         held_gamma_ff <= '0;
         held_beta_ff  <= '0;
         issued_ff     <= 1'b0;
         idx_ff        <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;

         if (csr_wr_en) begin
            unique case (csr_index)
               inorm_pkg::CSR_AFFINE:  affine_ff <= csr_wdata[0];
               inorm_pkg::CSR_EPSILON: eps_ff    <= csr_wdata;
               default:                affine_ff <= affine_ff;
            endcase
         end

         if (accept && count_ff == '0) begin
            held_gamma_ff <= req_item.scale_gamma;
            held_beta_ff  <= req_item.shift_beta;
         end
         sq_vld_ff <= store;
         if (store) begin
            sum_ff   <= sum_ff + inorm_pkg::SUM_W'(req_item.sample);
            count_ff <= count_ff + 1'b1;
         end
         if (sq_vld_ff) begin
            qsum_ff <= qsum_ff + inorm_pkg::QSUM_W'(sq_ff);
         end

         if (alu_cmd.start) begin
            issued_ff <= 1'b1;
         end else if (alu_done) begin
            issued_ff <= 1'b0;
         end

         if (state_ff == inorm_pkg::S_GAIN && state_in == inorm_pkg::S_READ) begin
            idx_ff <= '0;
         end

         if (state_ff == inorm_pkg::S_EMIT && out_free) begin
            rsp_valid_ff <= 1'b1;
            idx_ff       <= idx_ff + 1'b1;
            if (last_idx) begin
               count_ff <= '0;
               sum_ff   <= '0;
               qsum_ff  <= '0;
            end
         end else if (rsp_valid_ff && !rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // datapath
   always_ff @(posedge clock) begin
      sq_ff <= inorm_pkg::SQ_W'($signed(req_item.sample) * $signed(req_item.sample));
      unique case (state_ff)
         inorm_pkg::S_NQ: begin
            if (alu_done) work_ff <= alu_res;
         end
         inorm_pkg::S_SS: begin
            if (alu_done) work_ff <= (work_ff < alu_res) ? '0 : num_diff;
         end
         inorm_pkg::S_VAR: begin
            if (alu_done) work_ff <= (alu_res + W'(eps_ff)) << 16;
         end
         inorm_pkg::S_ROOT: begin
            if (alu_done) root_ff <= alu_res[inorm_pkg::ROOT_W-1:0];
         end
         inorm_pkg::S_GAIN: begin
            gain_neg_ff <= gamma_sel[inorm_pkg::SAMPLE_W-1];
            if (root_ff == '0) begin
               gain_mag_ff <= '0;
            end else if (alu_done) begin
               gain_mag_ff <= alu_res[inorm_pkg::GAIN_W-1:0];
            end
         end
         inorm_pkg::S_FETCH: begin
            dev_neg_ff <= dev[inorm_pkg::DEV_W-1];
            dev_mag_ff <= dev[inorm_pkg::DEV_W-1] ? 23'(-dev) : 23'(dev);
         end
         inorm_pkg::S_PROD: begin
            prod_neg_ff <= gain_neg_ff ^ dev_neg_ff;
            if (alu_done) work_ff <= alu_res + (W'(count_ff) << 15);
         end
         inorm_pkg::S_QUOT: begin
            if (alu_done) y_ff <= y_sat;
         end
         inorm_pkg::S_EMIT: begin
            if (out_free) begin
               rsp_item_ff.normalized    <= y_ff;
               rsp_item_ff.element_index <= inorm_pkg::IDX_W'(idx_ff);
               rsp_item_ff.last_result   <= last_idx;
            end
         end
         default: begin
            root_ff <= root_ff;
         end
      endcase
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;

endmodule

>>> design/inorm_ram.sv
// ----------------------------------------------------------------------------
// inorm_ram
// Generic single write port RAM with registered read.
// ----------------------------------------------------------------------------
module inorm_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> design/inorm_alu.sv
// ----------------------------------------------------------------------------
// inorm_alu
// Shared iterative unit: shift-add multiply, restoring divide and
// digit-by-digit square root, one step per cycle on one shared adder.
// ----------------------------------------------------------------------------
module inorm_alu (
   input  logic                      clock,
   input  logic                      reset,
   input  inorm_pkg::alu_cmd_type    cmd,
   output logic                      done,
   output logic [inorm_pkg::ALU_W-1:0] result
);

   localparam int W = inorm_pkg::ALU_W;

   logic                           busy_ff;
   logic                           done_ff;
   logic [inorm_pkg::STEP_W-1:0]   cnt_ff;
   inorm_pkg::alu_op_type          op_ff;
   logic [W-1:0]                   acc_ff;
   logic [W-1:0]                   a_ff;
   logic [W-1:0]                   b_ff;

   logic [W-1:0]                   add_x;
   logic [W-1:0]                   add_y;
   logic                           add_sub;
   logic [W:0]                     add_sum;
   logic                           ge;
   logic [inorm_pkg::STEP_W-1:0]   shamt_div;
   logic [inorm_pkg::STEP_W-1:0]   shamt_sqrt;

   assign shamt_div  = inorm_pkg::STEP_W'(W) - cmd.steps;
   assign shamt_sqrt = inorm_pkg::STEP_W'(W) - {cmd.steps[inorm_pkg::STEP_W-2:0], 1'b0};

   always_comb begin
      unique case (op_ff)
         inorm_pkg::ALU_MUL: begin
            add_x   = acc_ff;
            add_y   = a_ff;
            add_sub = 1'b0;
         end
         inorm_pkg::ALU_DIV: begin
            add_x   = {acc_ff[W-2:0], a_ff[W-1]};
            add_y   = b_ff;
            add_sub = 1'b1;
         end
         inorm_pkg::ALU_SQRT: begin
            add_x   = {acc_ff[W-3:0], a_ff[W-1:W-2]};
            add_y   = {b_ff[W-3:0], 2'b01};
            add_sub = 1'b1;
         end
         default: begin
            add_x   = acc_ff;
            add_y   = a_ff;
            add_sub = 1'b0;
         end
      endcase
      add_sum = {1'b0, add_x} + {1'b0, (add_sub ? ~add_y : add_y)} + (W+1)'(add_sub);
      ge      = add_sum[W];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
         op_ff   <= inorm_pkg::ALU_MUL;
      end else begin
         done_ff <= !cmd.start && busy_ff && (cnt_ff == inorm_pkg::STEP_W'(1));
         if (cmd.start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= cmd.steps;
            op_ff   <= cmd.op;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff - 1'b1;
            if (cnt_ff == inorm_pkg::STEP_W'(1)) begin
               busy_ff <= 1'b0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.start) begin
         acc_ff <= '0;
         unique case (cmd.op)
            inorm_pkg::ALU_MUL: begin
               a_ff <= cmd.opa;
               b_ff <= cmd.opb;
            end
            inorm_pkg::ALU_DIV: begin
               a_ff <= cmd.opa << shamt_div;
               b_ff <= cmd.opb;
            end
            inorm_pkg::ALU_SQRT: begin
               a_ff <= cmd.opa << shamt_sqrt;
               b_ff <= '0;
            end
            default: begin
               a_ff <= cmd.opa;
               b_ff <= cmd.opb;
            end
         endcase
      end else if (busy_ff) begin
         unique case (op_ff)
            inorm_pkg::ALU_MUL: begin
               if (b_ff[0]) begin
                  acc_ff <= add_sum[W-1:0];
               end
               a_ff <= {a_ff[W-2:0], 1'b0};
               b_ff <= {1'b0, b_ff[W-1:1]};
            end
            inorm_pkg::ALU_DIV: begin
               acc_ff <= ge ? add_sum[W-1:0] : add_x;
               a_ff   <= {a_ff[W-2:0], ge};
            end
            inorm_pkg::ALU_SQRT: begin
               acc_ff <= ge ? add_sum[W-1:0] : add_x;
               a_ff   <= {a_ff[W-3:0], 2'b00};
               b_ff   <= {b_ff[W-2:0], ge};
            end
            default: begin
               acc_ff <= acc_ff;
            end
         endcase
      end
   end

   always_comb begin
      unique case (op_ff)
         inorm_pkg::ALU_MUL:  result = acc_ff;
         inorm_pkg::ALU_DIV:  result = a_ff;
         inorm_pkg::ALU_SQRT: result = b_ff;
         default:             result = acc_ff;
      endcase
   end

   assign done = done_ff;

endmodule
